>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the median filter.
// Stands alone; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define RWMF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rwmf assertion failed");

// Checked at every rising edge, reset included.
`define RWMF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rwmf assertion failed");

`endif

>>> rtl/rwmf_pkg.sv
// Package of the RGB window median filter: widths, codes, types and reset values.
// Has no dependencies; the lane, the top level and the checker import it.
`timescale 1ns / 1ps

package rwmf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned RGB_W      = 3 * PIX_W;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned HALF_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned DEF_MAX_WIDTH       = 1024;
  localparam int unsigned DEF_MAX_HALF_WINDOW = 3;

  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [HALF_W-1:0] RST_HALF_WINDOW  = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HALF_WINDOW  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DELIVER
  } state_e;

  typedef struct packed {
    logic clr;
    logic ins;
  } lane_ctrl_t;

endpackage

>>> rtl/rwmf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rwmf_ram #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 7168,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rwmf_lane.sv
// One channel lane: keeps the window values of one channel in sorted order,
// taking one value per beat, and presents the selected rank. Uses rwmf_pkg.
`timescale 1ns / 1ps

module rwmf_lane
  import rwmf_pkg::*;
#(
  parameter int unsigned N       = 49,
  localparam int unsigned IDX_W  = $clog2(N)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctrl_t       ctrl_i,
  input  logic [PIX_W-1:0] data_i,
  input  logic [IDX_W-1:0] sel_i,
  output logic [PIX_W-1:0] median_o
);

  logic [PIX_W-1:0] val_q [N];
  logic [PIX_W-1:0] val_d [N];
  logic [N-1:0]     vld_q;
  logic [N-1:0]     vld_d;
  logic [N-1:0]     gt;

  // An empty slot counts as larger than any value, so the sorted run grows
  // from the bottom and each slot only looks at its lower neighbour.
  for (genvar i = 0; i < N; i++) begin : g_slot
    assign gt[i] = !vld_q[i] || (val_q[i] > data_i);
    if (i == 0) begin : g_first
      assign val_d[i] = gt[i] ? data_i : val_q[i];
      assign vld_d[i] = 1'b1;
    end else begin : g_rest
      assign val_d[i] = gt[i] ? (gt[i-1] ? val_q[i-1] : data_i) : val_q[i];
      assign vld_d[i] = vld_q[i] | vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl_i.clr) begin
      vld_q <= '0;
    end else if (ctrl_i.ins) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !ctrl_i.clr) begin
      val_q <= val_d;
    end
  end

  assign median_o = val_q[sel_i];

endmodule

>>> rtl/rgb_window_median_filter.sv
// Top level of the RGB window median filter: line store, position tracking,
// window read sequencer, three channel lanes and the output stage.
// Uses rwmf_pkg, rwmf_ram and rwmf_lane.
`timescale 1ns / 1ps

// Pixels enter in raster order and results leave h rows and h pixels later; flush
// beats drain the tail of the frame and frame_last_o marks its final pixel. A
// beat that gives no result returns to idle, a border result goes to the deliver
// state, and an interior result reads the window from the single read port of the
// line store one pixel per cycle, sorted by the three channel lanes in parallel,
// then drains and delivers. The line store needs no clearing pass after reset.
module rgb_window_median_filter
  import rwmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [PIX_W-1:0]      in_blue_i,
  input  logic [PIX_W-1:0]      in_green_i,
  input  logic [PIX_W-1:0]      in_red_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_red_o,
  output logic                  frame_last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned STORE_ROWS = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned WIN_N      = STORE_ROWS * STORE_ROWS;
  localparam int unsigned DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RMW        = $clog2(STORE_ROWS);
  localparam int unsigned HW         = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned SW         = $clog2(STORE_ROWS);
  localparam int unsigned IDXW       = $clog2(WIN_N);
  localparam int unsigned DW         = $clog2(MAX_HALF_WINDOW * MAX_WIDTH + MAX_HALF_WINDOW + 2);
  localparam int unsigned RXW        = FH_W + 1;
  localparam int unsigned CXW        = WW + 1;
  localparam logic [RMW-1:0] RMOD_LAST = RMW'(STORE_ROWS - 1);

  state_e          state_q, state_d;
  logic            rdy_en_q;
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic [HALF_W-1:0] half_window_q;

  logic [CW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [FH_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [RMW-1:0]  in_rmod_q, in_rmod_d, out_rmod_q, out_rmod_d;
  logic [DW-1:0]   lag_q, lag_d;
  logic [RMW-1:0]  rd_rmod_q, rd_rmod_d;
  logic [CW-1:0]   rd_col_q, rd_col_d, col_base_q, col_base_d;
  logic [SW-1:0]   win_r_q, win_r_d, win_c_q, win_c_d;
  logic            rd_vld_q;
  logic            job_border_q, job_border_d, job_last_q, job_last_d;
  logic [RGB_W-1:0] first_px_q;
  logic            out_valid_q;
  logic [RGB_W-1:0] out_px_q;
  logic            out_last_q;

  logic [WW-1:0]   w_eff, w_last;
  logic [FH_W-1:0] ht_eff, ht_last;
  logic [HW-1:0]   h_eff;
  logic [DW-1:0]   delay, lag_inc;
  logic [IDXW-1:0] med_sel;
  logic [SW-1:0]   win_last;
  logic            acc, is_pix, in_full, pix_take, emit, border, out_last, cfg_hit;
  logic [RMW-1:0]  start_rmod;
  logic [CW-1:0]   start_col;
  logic            ram_we, first_px_we, out_load;
  logic [AW-1:0]   waddr, raddr;
  logic [RGB_W-1:0] rdata, med_px;
  lane_ctrl_t      lane_ctrl;

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end
    ht_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
    if (32'(half_window_q) > MAX_HALF_WINDOW) begin
      h_eff = HW'(MAX_HALF_WINDOW);
    end else begin
      h_eff = HW'(half_window_q);
    end
  end

  assign w_last   = w_eff - WW'(1);
  assign ht_last  = ht_eff - FH_W'(1);
  assign delay    = DW'(h_eff) * DW'(w_eff) + DW'(h_eff);
  assign lag_inc  = lag_q + DW'(1);
  assign med_sel  = IDXW'(32'(h_eff) * (32'(h_eff) + 32'd1) * 32'd2);
  assign win_last = SW'({h_eff, 1'b0});

  assign in_ready_o = rdy_en_q && (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign is_pix     = req_e'(req_type_i) == REQ_PIXEL;
  assign in_full    = in_row_q >= ht_eff;
  assign pix_take   = acc && is_pix && !in_full;
  assign emit       = (pix_take && (lag_inc > delay)) || (acc && !is_pix && in_full);
  assign out_last   = (out_row_q == ht_last) && (WW'(out_col_q) == w_last);
  assign border     = (RXW'(out_row_q) < RXW'(h_eff))
                   || (RXW'(out_row_q) + RXW'(h_eff) >= RXW'(ht_eff))
                   || (CXW'(out_col_q) < CXW'(h_eff))
                   || (CXW'(out_col_q) + CXW'(h_eff) >= CXW'(w_eff));
  assign start_rmod = (out_rmod_q >= RMW'(h_eff)) ? out_rmod_q - RMW'(h_eff)
                                                  : out_rmod_q + RMW'(STORE_ROWS) - RMW'(h_eff);
  assign start_col  = out_col_q - CW'(h_eff);
  assign cfg_hit    = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_FRAME_WIDTH)
                   || (cfg_idx_e'(cfg_idx_i) == CFG_FRAME_HEIGHT)
                   || (cfg_idx_e'(cfg_idx_i) == CFG_HALF_WINDOW));

  assign waddr = AW'(in_rmod_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
  assign raddr = AW'(rd_rmod_q) * AW'(MAX_WIDTH) + AW'(rd_col_q);

  always_comb begin
    state_d      = state_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    in_rmod_d    = in_rmod_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_rmod_d   = out_rmod_q;
    lag_d        = lag_q;
    rd_rmod_d    = rd_rmod_q;
    rd_col_d     = rd_col_q;
    col_base_d   = col_base_q;
    win_r_d      = win_r_q;
    win_c_d      = win_c_q;
    job_border_d = job_border_q;
    job_last_d   = job_last_q;
    ram_we       = 1'b0;
    first_px_we  = 1'b0;
    out_load     = 1'b0;
    lane_ctrl.clr = 1'b0;
    lane_ctrl.ins = rd_vld_q;

    unique case (state_q)
      S_IDLE: begin
        if (pix_take) begin
          ram_we = 1'b1;
          first_px_we = (in_row_q == '0) && (in_col_q == '0);
          if (WW'(in_col_q) == w_last) begin
            in_col_d  = '0;
            in_row_d  = in_row_q + FH_W'(1);
            in_rmod_d = (in_rmod_q == RMOD_LAST) ? '0 : in_rmod_q + RMW'(1);
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
        end
        if (acc) begin
          lag_d = lag_q + DW'(pix_take) - DW'(emit);
        end
        if (emit) begin
          job_border_d = border;
          job_last_d   = out_last;
          rd_rmod_d    = start_rmod;
          rd_col_d     = start_col;
          col_base_d   = start_col;
          win_r_d      = '0;
          win_c_d      = '0;
          if (out_last) begin
            in_col_d   = '0;
            in_row_d   = '0;
            in_rmod_d  = '0;
            out_col_d  = '0;
            out_row_d  = '0;
            out_rmod_d = '0;
            lag_d      = '0;
          end else if (WW'(out_col_q) == w_last) begin
            out_col_d  = '0;
            out_row_d  = out_row_q + FH_W'(1);
            out_rmod_d = (out_rmod_q == RMOD_LAST) ? '0 : out_rmod_q + RMW'(1);
          end else begin
            out_col_d = out_col_q + CW'(1);
          end
          if (border) begin
            state_d = S_DELIVER;
          end else begin
            state_d = S_RUN;
            lane_ctrl.clr = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (win_c_q == win_last) begin
          win_c_d   = '0;
          rd_col_d  = col_base_q;
          rd_rmod_d = (rd_rmod_q == RMOD_LAST) ? '0 : rd_rmod_q + RMW'(1);
          win_r_d   = win_r_q + SW'(1);
          if (win_r_q == win_last) begin
            state_d = S_DRAIN;
          end
        end else begin
          win_c_d  = win_c_q + SW'(1);
          rd_col_d = rd_col_q + CW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DELIVER;
      end
      S_DELIVER: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_hit) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_rmod_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_rmod_d = '0;
      lag_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rdy_en_q       <= 1'b0;
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      half_window_q  <= RST_HALF_WINDOW;
      in_col_q       <= '0;
      in_row_q       <= '0;
      in_rmod_q      <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_rmod_q     <= '0;
      lag_q          <= '0;
      rd_rmod_q      <= '0;
      rd_col_q       <= '0;
      col_base_q     <= '0;
      win_r_q        <= '0;
      win_c_q        <= '0;
      rd_vld_q       <= 1'b0;
      job_border_q   <= 1'b0;
      job_last_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rdy_en_q     <= 1'b1;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      in_rmod_q    <= in_rmod_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_rmod_q   <= out_rmod_d;
      lag_q        <= lag_d;
      rd_rmod_q    <= rd_rmod_d;
      rd_col_q     <= rd_col_d;
      col_base_q   <= col_base_d;
      win_r_q      <= win_r_d;
      win_c_q      <= win_c_d;
      rd_vld_q     <= (state_q == S_RUN);
      job_border_q <= job_border_d;
      job_last_q   <= job_last_d;
      out_valid_q  <= out_load || (out_valid_q && !out_ready_i);
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
          CFG_HALF_WINDOW:  half_window_q  <= cfg_data_i[HALF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_px_we) begin
      first_px_q <= {in_red_i, in_green_i, in_blue_i};
    end
    if (out_load) begin
      out_px_q   <= job_border_q ? first_px_q : med_px;
      out_last_q <= job_last_q;
    end
  end

  rwmf_ram #(
    .DATA_W (RGB_W),
    .DEPTH  (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rwmf_lane #(
      .N (WIN_N)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .data_i   (rdata[l*PIX_W +: PIX_W]),
      .sel_i    (med_sel),
      .median_o (med_px[l*PIX_W +: PIX_W])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign out_blue_o   = out_px_q[0 +: PIX_W];
  assign out_green_o  = out_px_q[PIX_W +: PIX_W];
  assign out_red_o    = out_px_q[2*PIX_W +: PIX_W];
  assign frame_last_o = out_last_q;

endmodule

>>> rtl/rwmf_checker.sv
// Port-level checker of the RGB window median filter and its bind to the top level.
// Uses rwmf_pkg and the macros of assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rwmf_checker
  import rwmf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  req_type_i,
  input logic [PIX_W-1:0]      in_blue_i,
  input logic [PIX_W-1:0]      in_green_i,
  input logic [PIX_W-1:0]      in_red_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [PIX_W-1:0]      out_blue_o,
  input logic [PIX_W-1:0]      out_green_o,
  input logic [PIX_W-1:0]      out_red_o,
  input logic                  frame_last_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // A result beat that is not taken holds its value.
  `RWMF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_blue_o) && $stable(out_green_o) && $stable(out_red_o) && $stable(frame_last_o))

  // A new result only appears after the input side has been busy.
  `RWMF_ASSERT(a_rise_busy, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_ready_o))

  // Without an input beat the block stays ready, configuration writes included.
  `RWMF_ASSERT(a_idle_stays, clk_i, rst_ni, in_ready_o && !in_valid_i |=> in_ready_o)

  // Reset leaves no result offered and the input not ready.
  `RWMF_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o && !in_ready_o)

endmodule

bind rgb_window_median_filter rwmf_checker u_rwmf_checker (.*);
